// ----- hdl/mu8d_pkg.sv -----
// Shared types, constants and the code point encoder for the modified UTF-8 decoder.
package mu8d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_JOB_BYTES = 6;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [3:0][7:0] REPLACEMENT_UTF8 = {8'h00, 8'hBD, 8'hBF, 8'hEF};

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG = 6'b110111;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;

    typedef struct packed {
        logic [MAX_JOB_BYTES-1:0][7:0] bytes;
        logic [2:0] count;
        logic malformed;
        logic eos;
    } job_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0] len;
    } enc_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        begin
            e.bytes = '0;
            if (cp < 21'h000080) begin
                e.bytes[0] = cp[7:0];
                e.len = 3'd1;
            end else if (cp < 21'h000800) begin
                e.bytes[0] = {3'b110, cp[10:6]};
                e.bytes[1] = {2'b10, cp[5:0]};
                e.len = 3'd2;
            end else if (cp < 21'h010000) begin
                e.bytes[0] = {4'b1110, cp[15:12]};
                e.bytes[1] = {2'b10, cp[11:6]};
                e.bytes[2] = {2'b10, cp[5:0]};
                e.len = 3'd3;
            end else begin
                e.bytes[0] = {5'b11110, cp[20:18]};
                e.bytes[1] = {2'b10, cp[17:12]};
                e.bytes[2] = {2'b10, cp[11:6]};
                e.bytes[3] = {2'b10, cp[5:0]};
                e.len = 3'd4;
            end
            return e;
        end
    endfunction

endpackage

// ----- hdl/mu8d_front.sv -----
// Front end: decodes input bytes into units, pairs surrogates and builds output byte jobs.
module mu8d_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             last,
    output logic             push,
    output mu8d_pkg::job_t   push_job
);

    logic [1:0]  cont_reg, cont_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic        held_reg, held_next;
    logic        drop_reg, drop_next;

    logic        err;
    logic        unit_ok;
    logic [15:0] unit;
    logic [15:0] acc_step;
    logic        pre_fffd;
    logic        emit_cp;
    logic        post_fffd;
    logic [20:0] cp;
    mu8d_pkg::enc_t enc;
    logic [2:0]  p0;
    logic [2:0]  p1;
    logic [2:0]  ii;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        cont_next = cont_reg;
        acc_next  = acc_reg;
        hs_next   = hs_reg;
        held_next = held_reg;
        drop_next = drop_reg;
        err       = 1'b0;
        unit_ok   = 1'b0;
        unit      = '0;
        acc_step  = {acc_reg[9:0], data_byte[5:0]};
        pre_fffd  = 1'b0;
        emit_cp   = 1'b0;
        post_fffd = 1'b0;
        cp        = '0;

        if (drop_reg)
        begin
            if (last)
            begin
                drop_next = 1'b0;
                cont_next = '0;
                acc_next  = '0;
                hs_next   = '0;
                held_next = 1'b0;
            end
        end
        else
        begin
            if (cont_reg == 2'd0)
            begin
                if (!data_byte[7])
                begin
                    unit_ok = 1'b1;
                    unit    = {8'h00, data_byte};
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    acc_next  = {11'h000, data_byte[4:0]};
                    cont_next = 2'd1;
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    acc_next  = {12'h000, data_byte[3:0]};
                    cont_next = 2'd2;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                err = 1'b1;
            end
            else
            begin
                cont_next = cont_reg - 2'd1;
                if (cont_next == 2'd0)
                begin
                    unit_ok  = 1'b1;
                    unit     = acc_step;
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_step;
                end
            end

            if (!err && last && cont_next != 2'd0)
            begin
                err = 1'b1;
            end

            if (unit_ok)
            begin
                if (unit[15:10] == mu8d_pkg::HIGH_SURR_TAG)
                begin
                    pre_fffd  = held_reg;
                    hs_next   = unit[9:0];
                    held_next = 1'b1;
                end
                else if (unit[15:10] == mu8d_pkg::LOW_SURR_TAG)
                begin
                    emit_cp = 1'b1;
                    if (held_reg)
                    begin
                        cp = mu8d_pkg::SUPPLEMENTARY_BASE + {1'b0, hs_reg, unit[9:0]};
                        held_next = 1'b0;
                        hs_next   = '0;
                    end
                    else
                    begin
                        cp = mu8d_pkg::REPLACEMENT_CP;
                    end
                end
                else
                begin
                    pre_fffd  = held_reg;
                    held_next = 1'b0;
                    hs_next   = '0;
                    emit_cp   = 1'b1;
                    cp        = {5'b00000, unit};
                end
            end

            if (err)
            begin
                cont_next = '0;
                acc_next  = '0;
                hs_next   = '0;
                held_next = 1'b0;
                drop_next = !last;
                pre_fffd  = 1'b0;
                emit_cp   = 1'b0;
            end
            else if (last)
            begin
                post_fffd = held_next;
                cont_next = '0;
                acc_next  = '0;
                hs_next   = '0;
                held_next = 1'b0;
            end
        end
    end

    assign enc = mu8d_pkg::encode_cp(cp);
    assign p0  = pre_fffd ? 3'd3 : 3'd0;
    assign p1  = p0 + (emit_cp ? enc.len : 3'd0);

    always_comb
    begin
        ii = '0;
        push_job = '0;
        if (err)
        begin
            push_job.bytes[0]  = 8'h00;
            push_job.count     = 3'd1;
            push_job.malformed = 1'b1;
            push_job.eos       = last;
        end
        else
        begin
            for (int i = 0; i < mu8d_pkg::MAX_JOB_BYTES; i++)
            begin
                ii = 3'(i);
                if (ii < p0)
                begin
                    push_job.bytes[i] = mu8d_pkg::REPLACEMENT_UTF8[ii[1:0]];
                end
                else if (ii < p1)
                begin
                    push_job.bytes[i] = enc.bytes[2'(ii - p0)];
                end
                else
                begin
                    push_job.bytes[i] = mu8d_pkg::REPLACEMENT_UTF8[2'(ii - p1)];
                end
            end
            push_job.count     = p1 + (post_fffd ? 3'd3 : 3'd0);
            push_job.malformed = 1'b0;
            push_job.eos       = last;
        end
    end

    assign push = accept && (push_job.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg <= '0;
            acc_reg  <= '0;
            hs_reg   <= '0;
            held_reg <= 1'b0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            cont_reg <= cont_next;
            acc_reg  <= acc_next;
            hs_reg   <= hs_next;
            held_reg <= held_next;
            drop_reg <= drop_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cont_reg != 2'd3)
        else $error("continuation count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> (cont_reg == 2'd0 && !held_reg))
        else $error("decoder state not cleared while dropping a malformed string");

endmodule

// ----- hdl/mu8d_queue.sv -----
// Job queue between the decoding front end and the byte output back end.
module mu8d_queue #(
    parameter int DEPTH = mu8d_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mu8d_pkg::job_t push_job,
    input  logic           pop,
    output mu8d_pkg::job_t head_job,
    output logic           not_empty,
    output logic           full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mu8d_pkg::job_t entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == CW'(DEPTH);
    assign head_job  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
        else $error("job popped from an empty queue");

endmodule

// ----- hdl/mu8d_back.sv -----
// Back end: sends the bytes of each queued job through the output register.
module mu8d_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mu8d_pkg::job_t head_job,
    input  logic           not_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           malformed,
    output logic           end_of_string
);

    logic       valid_reg, valid_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       malformed_reg, malformed_next;
    logic       eos_reg, eos_next;
    logic       load;
    logic       take;
    logic       job_done;

    assign load     = !valid_reg || out_ready;
    assign take     = load && not_empty;
    assign job_done = idx_reg == (head_job.count - 3'd1);
    assign pop      = take && job_done;

    always_comb
    begin
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        malformed_next = malformed_reg;
        eos_next       = eos_reg;
        if (load)
        begin
            valid_next = not_empty;
        end
        if (take)
        begin
            byte_next      = head_job.bytes[idx_reg];
            malformed_next = head_job.malformed;
            eos_next       = head_job.eos && job_done;
            idx_next       = job_done ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        malformed_reg <= malformed_next;
        eos_reg       <= eos_next;
    end

    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign malformed     = malformed_reg;
    assign end_of_string = eos_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && malformed_reg) |-> (byte_reg == 8'h00 && idx_reg == 3'd0))
        else $error("malformed result carries data or is not a single-byte job");

    assert property (@(posedge clk) disable iff (!rst_n)
        not_empty |-> (idx_reg < head_job.count))
        else $error("byte index runs past the end of the head job");

endmodule

// ----- hdl/modified_utf8_to_utf8_decoder_top.sv -----
// Top level of the modified UTF-8 to standard UTF-8 stream decoder.
// Accepts one input byte per cycle whenever the job queue has room and emits one
// standard UTF-8 byte per cycle while out_ready is high. An input byte that yields
// k output bytes (0 to 6) presents them on the output port one after another;
// ordinary text yields no more output bytes than input bytes and so streams at one
// byte per cycle. The queue of QUEUE_DEPTH jobs absorbs bursts of multi-byte
// output, and the first output byte of a job is written into the queue and then
// loaded into the output register.
module modified_utf8_to_utf8_decoder_top #(
    parameter int QUEUE_DEPTH = mu8d_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       malformed,
    output logic       end_of_string
);

    logic           push;
    mu8d_pkg::job_t push_job;
    logic           pop;
    mu8d_pkg::job_t head_job;
    logic           not_empty;
    logic           full;

    assign in_ready = !full;

    mu8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last      (last),
        .push      (push),
        .push_job  (push_job)
    );

    mu8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .head_job  (head_job),
        .not_empty (not_empty),
        .full      (full)
    );

    mu8d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .not_empty     (not_empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .malformed     (malformed),
        .end_of_string (end_of_string)
    );

endmodule
